[sv/fba_pkg.sv]
// fba_pkg: shared types and constants for the Fourier basis approximator.
// Used by the channel interfaces and the top level. No dependencies.
package fba_pkg;

  typedef logic [1:0]         action_t;
  typedef logic signed [15:0] point_t;
  typedef logic signed [31:0] q16_t;
  typedef logic [3:0]         repeat_t;
  typedef logic [7:0]         windex_t;

  localparam action_t ACT_EVAL  = 2'd0;
  localparam action_t ACT_LEARN = 2'd1;
  localparam action_t ACT_LOAD  = 2'd2;

  localparam logic [2:0] REG_ORDER  = 3'd0;
  localparam logic [2:0] REG_INPUTS = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_STEP   = 3'd3;
  localparam logic [2:0] REG_PERIOD = 3'd4;

  // Horner coefficients of the quarter-wave cosine polynomial, Q30
  localparam logic signed [33:0] HORNER_P0 = 34'sd987048;
  localparam logic signed [33:0] HORNER_C [0:3] = '{
    34'sd22401992, 34'sd272375560, 34'sd1324675879, 34'sd1073741824
  };

endpackage

[sv/fba_req_if.sv]
// fba_req_if: request channel (valid/ready plus item payload).
// Depends on fba_pkg.
interface fba_req_if;
  import fba_pkg::*;
  logic    valid;
  logic    ready;
  action_t action;
  point_t  point_x0;
  point_t  point_x1;
  point_t  point_x2;
  point_t  point_x3;
  q16_t    target_value;
  repeat_t repeat_count;
  windex_t weight_index;
  q16_t    weight_data;
  modport source (output valid, action, point_x0, point_x1, point_x2, point_x3,
                  target_value, repeat_count, weight_index, weight_data, input ready);
  modport sink (input valid, action, point_x0, point_x1, point_x2, point_x3,
                target_value, repeat_count, weight_index, weight_data, output ready);
endinterface

[sv/fba_rsp_if.sv]
// fba_rsp_if: result channel (valid/ready plus approx_value).
// Depends on fba_pkg.
interface fba_rsp_if;
  import fba_pkg::*;
  logic valid;
  logic ready;
  q16_t approx_value;
  modport source (output valid, approx_value, input ready);
  modport sink (input valid, approx_value, output ready);
endinterface

[sv/fourier_basis_approximator.sv]
// fourier_basis_approximator: Fourier-basis linear approximator, one shared multiplier
// and a bit-serial restoring divider under a sequencer. Depends on fba_pkg, fba_req_if, fba_rsp_if.
// Load writes one weight if its index is in range; evaluate builds the features, then sums;
// learn: each iteration updates every weight through the bit-serial divider, and all but
// the last then form the next sum. One transaction at a time, ready only when idle.
// Reset: registers take reset values, then a clearing pass zeroes the weights.
module fourier_basis_approximator #(
  parameter int MAX_INPUTS = 4,
  parameter int MAX_ORDER  = 3,
  parameter int MAX_BASIS  = 256
) (
  input  logic        clk,
  input  logic        rst,
  fba_req_if.sink     req,
  fba_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fba_pkg::*;

  localparam int DW   = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
  localparam int MIW  = $clog2(MAX_INPUTS + 1);
  localparam int NW   = $clog2(MAX_BASIS + 1);
  localparam int AW   = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int DOTW = 17 + DW + MIW;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_MW    = 5'd2;
  localparam logic [4:0] S_FDOT  = 5'd3;
  localparam logic [4:0] S_FPH   = 5'd4;
  localparam logic [4:0] S_FZZ   = 5'd5;
  localparam logic [4:0] S_FH    = 5'd6;
  localparam logic [4:0] S_FNRM  = 5'd7;
  localparam logic [4:0] S_ERD   = 5'd8;
  localparam logic [4:0] S_EMUL  = 5'd9;
  localparam logic [4:0] S_EACC  = 5'd10;
  localparam logic [4:0] S_EDONE = 5'd11;
  localparam logic [4:0] S_URD   = 5'd12;
  localparam logic [4:0] S_UM1   = 5'd13;
  localparam logic [4:0] S_UM2   = 5'd14;
  localparam logic [4:0] S_UDIV0 = 5'd15;
  localparam logic [4:0] S_UDIV  = 5'd16;
  localparam logic [4:0] S_UWR   = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;

  // configuration
  logic [1:0]  order;
  logic [2:0]  input_count;
  logic        coupled_mode;
  logic [15:0] step_size;
  logic [31:0] period_scale;

  // sequencer state
  logic [4:0]  state;
  logic [4:0]  ret;
  logic [NW-1:0] idx;
  logic [NW-1:0] nbasis;
  logic [DW-1:0] kk;
  logic [MIW-1:0] mm;
  logic [DW-1:0] c [0:MAX_INPUTS-1];
  logic [MIW-1:0] ax;
  logic [DW-1:0] jj;
  logic [1:0]  hstep;
  logic [1:0]  act;
  logic [3:0]  reps;
  logic        out_valid;
  q16_t        out_data;

  // payload
  point_t      xr [0:MAX_INPUTS-1];
  q16_t        target;
  q16_t        delta;
  q16_t        result;
  logic [31:0] zsq;
  logic        fneg;
  logic [63:0] norm;
  logic signed [63:0] acc;
  logic [63:0] dq;
  logic [63:0] rem;
  logic [6:0]  dcnt;
  logic        qneg;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] mul_p;

  // memories
  q16_t               wmem [0:MAX_BASIS-1];
  logic signed [17:0] fmem [0:MAX_BASIS-1];
  q16_t               w_rdata;
  logic signed [17:0] f_rdata;
  logic               w_we;
  logic [AW-1:0]      w_addr;
  q16_t               w_wd;
  logic               f_we;

  function automatic q16_t sat32(input logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [NW-1:0] basis_total(input logic cm, input logic [DW-1:0] k,
                                                input logic [MIW-1:0] m);
    logic [NW+3:0] t;
    t = (NW+4)'(1);
    if (cm) begin
      for (int a = 0; a < MAX_INPUTS; a++) begin
        if (a < int'(m)) begin
          t = t * ((NW+4)'(k) + (NW+4)'(1));
          if (t > (NW+4)'(MAX_BASIS)) t = (NW+4)'(MAX_BASIS);
        end
      end
    end else begin
      t = (NW+4)'(m) * ((NW+4)'(k) + (NW+4)'(1));
      if (t > (NW+4)'(MAX_BASIS)) t = (NW+4)'(MAX_BASIS);
    end
    return t[NW-1:0];
  endfunction

  logic accept;
  logic cfg_we;
  logic [DW-1:0] k_cl;
  logic [MIW-1:0] m_cl;
  logic signed [DOTW-1:0] dot;
  logic [DW-1:0] c_nx [0:MAX_INPUTS-1];
  logic [MIW-1:0] ax_nx;
  logic [DW-1:0] jj_nx;
  logic carry;
  logic [15:0] phase;
  logic [14:0] zval;
  logic signed [33:0] hp_nx;
  logic signed [33:0] hp_pos;
  logic [33:0] fround;
  logic signed [17:0] fval;
  logic signed [63:0] ev_sh;
  q16_t ev;
  q16_t ev_delta;
  logic [64:0] rem_sh;
  logic signed [63:0] qs;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.approx_value = out_data;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_ORDER:  prdata = {30'b0, order};
      REG_INPUTS: prdata = {29'b0, input_count};
      REG_MODE:   prdata = {31'b0, coupled_mode};
      REG_STEP:   prdata = {16'b0, step_size};
      REG_PERIOD: prdata = period_scale;
      default:    prdata = 32'b0;
    endcase
  end

  always_comb begin
    k_cl = (int'(order) > MAX_ORDER) ? DW'(MAX_ORDER) : DW'(order);
    m_cl = (int'(input_count) > MAX_INPUTS) ? MIW'(MAX_INPUTS) : MIW'(input_count);
  end

  // dot product of basis vector and point, narrow products
  always_comb begin
    dot = '0;
    for (int a = 0; a < MAX_INPUTS; a++) begin
      dot = dot + DOTW'($signed({1'b0, c[a]})) * DOTW'(xr[a]);
    end
  end

  // next basis vector
  always_comb begin
    carry = 1'b1;
    ax_nx = ax;
    jj_nx = jj;
    for (int a = 0; a < MAX_INPUTS; a++) c_nx[a] = c[a];
    if (coupled_mode) begin
      for (int a = 0; a < MAX_INPUTS; a++) begin
        if (carry && (a < int'(mm))) begin
          if (c[a] == kk) begin
            c_nx[a] = '0;
          end else begin
            c_nx[a] = c[a] + DW'(1);
            carry = 1'b0;
          end
        end
      end
    end else begin
      if (jj == kk) begin
        jj_nx = '0;
        ax_nx = ax + MIW'(1);
      end else begin
        jj_nx = jj + DW'(1);
      end
      for (int a = 0; a < MAX_INPUTS; a++) begin
        c_nx[a] = (MIW'(a) == ax_nx) ? jj_nx : '0;
      end
    end
  end

  always_comb begin
    phase  = mul_p[24:9];
    zval   = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    hp_nx  = HORNER_C[hstep] - 34'(mul_p >>> 30);
    hp_pos = hp_nx[33] ? 34'sd0 : hp_nx;
    fround = hp_pos + 34'sd8192;
    fval   = fneg ? -$signed({1'b0, fround[30:14]}) : $signed({1'b0, fround[30:14]});
    ev_sh  = (acc + 64'sd32768) >>> 16;
    ev     = sat32(67'(ev_sh));
    ev_delta = sat32(67'(target) - 67'(ev));
    rem_sh = {rem, dq[63]};
    qs     = qneg ? -$signed(dq) : $signed(dq);
  end

  always_comb begin
    w_we   = 1'b0;
    w_addr = idx[AW-1:0];
    w_wd   = '0;
    f_we   = (state == S_FH) && (hstep == 2'd3);
    case (state)
      S_CLR: w_we = 1'b1;
      S_IDLE: begin
        w_addr = AW'(req.weight_index);
        w_wd   = req.weight_data;
        w_we   = accept && (req.action == ACT_LOAD) && (int'(req.weight_index) < MAX_BASIS);
      end
      S_UWR: begin
        w_we = 1'b1;
        w_wd = sat32(67'(w_rdata) + 67'(qs));
      end
      default: w_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_addr] <= w_wd;
    if (f_we) fmem[idx[AW-1:0]] <= fval;
    w_rdata <= wmem[idx[AW-1:0]];
    f_rdata <= fmem[idx[AW-1:0]];
    mul_p   <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order        <= 2'd3;
      input_count  <= 3'd1;
      coupled_mode <= 1'b1;
      step_size    <= 16'd6554;
      period_scale <= 32'd65536;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_ORDER:  order        <= pwdata[1:0];
        REG_INPUTS: input_count  <= pwdata[2:0];
        REG_MODE:   coupled_mode <= pwdata[0];
        REG_STEP:   step_size    <= pwdata[15:0];
        REG_PERIOD: period_scale <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      ret       <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_CLR: begin
          idx <= idx + NW'(1);
          if (idx == NW'(MAX_BASIS - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            act    <= req.action;
            target <= req.target_value;
            reps   <= req.repeat_count;
            for (int a = 0; a < MAX_INPUTS; a++) begin
              case (a)
                0: xr[a] <= req.point_x0;
                1: xr[a] <= req.point_x1;
                2: xr[a] <= req.point_x2;
                3: xr[a] <= req.point_x3;
                default: xr[a] <= '0;
              endcase
              c[a] <= '0;
            end
            kk     <= k_cl;
            mm     <= m_cl;
            ax     <= '0;
            jj     <= '0;
            idx    <= '0;
            norm   <= '0;
            acc    <= '0;
            nbasis <= basis_total(coupled_mode, k_cl, m_cl);
            result <= '0;
            if (req.action == ACT_EVAL || req.action == ACT_LEARN) begin
              state <= (basis_total(coupled_mode, k_cl, m_cl) == '0) ? S_EDONE : S_FDOT;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_MW: state <= ret;
        S_FDOT: begin
          mul_a <= 34'(dot);
          mul_b <= {1'b0, period_scale};
          ret   <= S_FPH;
          state <= S_MW;
        end
        S_FPH: begin
          fneg  <= phase[15] ^ phase[14];
          mul_a <= {19'b0, zval};
          mul_b <= {18'b0, zval};
          ret   <= S_FZZ;
          state <= S_MW;
        end
        S_FZZ: begin
          zsq   <= {mul_p[29:0], 2'b00};
          hstep <= 2'd0;
          mul_a <= HORNER_P0;
          mul_b <= {1'b0, mul_p[29:0], 2'b00};
          ret   <= S_FH;
          state <= S_MW;
        end
        S_FH: begin
          if (hstep == 2'd3) begin
            mul_a <= 34'(fval);
            mul_b <= 33'(fval);
            ret   <= S_FNRM;
          end else begin
            hstep <= hstep + 2'd1;
            mul_a <= hp_nx;
            mul_b <= {1'b0, zsq};
            ret   <= S_FH;
          end
          state <= S_MW;
        end
        S_FNRM: begin
          norm <= norm + mul_p[63:0];
          for (int a = 0; a < MAX_INPUTS; a++) c[a] <= c_nx[a];
          ax <= ax_nx;
          jj <= jj_nx;
          if (idx + NW'(1) == nbasis) begin
            idx   <= '0;
            acc   <= '0;
            state <= S_ERD;
          end else begin
            idx   <= idx + NW'(1);
            state <= S_FDOT;
          end
        end
        S_ERD: state <= S_EMUL;
        S_EMUL: begin
          mul_a <= 34'(w_rdata);
          mul_b <= 33'(f_rdata);
          ret   <= S_EACC;
          state <= S_MW;
        end
        S_EACC: begin
          acc <= acc + mul_p[63:0];
          if (idx + NW'(1) == nbasis) begin
            state <= S_EDONE;
          end else begin
            idx   <= idx + NW'(1);
            state <= S_ERD;
          end
        end
        S_EDONE: begin
          idx <= '0;
          if (act == ACT_EVAL) begin
            result <= ev;
            state  <= S_FIN;
          end else begin
            result <= ev_delta;
            delta  <= ev_delta;
            state  <= (reps == 4'd0 || norm == 64'd0) ? S_FIN : S_URD;
          end
        end
        S_URD: state <= S_UM1;
        S_UM1: begin
          mul_a <= 34'(f_rdata);
          mul_b <= {17'b0, step_size};
          ret   <= S_UM2;
          state <= S_MW;
        end
        S_UM2: begin
          mul_a <= mul_p[33:0];
          mul_b <= 33'(delta);
          ret   <= S_UDIV0;
          state <= S_MW;
        end
        S_UDIV0: begin
          qneg  <= mul_p[63];
          dq    <= mul_p[63] ? 64'(-mul_p[63:0]) : mul_p[63:0];
          rem   <= '0;
          dcnt  <= '0;
          state <= S_UDIV;
        end
        S_UDIV: begin
          if (rem_sh >= {1'b0, norm}) begin
            rem <= 64'(rem_sh - {1'b0, norm});
            dq  <= {dq[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            dq  <= {dq[62:0], 1'b0};
          end
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd63) state <= S_UWR;
        end
        S_UWR: begin
          if (idx + NW'(1) == nbasis) begin
            idx  <= '0;
            reps <= reps - 4'd1;
            if (reps == 4'd1) begin
              state <= S_FIN;
            end else begin
              acc   <= '0;
              state <= S_ERD;
            end
          end else begin
            idx   <= idx + NW'(1);
            state <= S_URD;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
